>>> hw/rtl/msf_pkg.sv
package msf_pkg;

	localparam int unsigned SampleW   = 12;
	localparam int unsigned LevelW    = 16;
	localparam int unsigned OffsetW   = 16;
	localparam int unsigned WeightW   = 8;
	localparam int unsigned AccW      = 32;
	localparam int unsigned CountW    = 8;
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned SlowPeriod = 212;

	localparam logic [CountW-1:0] SlowLast = CountW'(SlowPeriod - 1);

	localparam logic [LevelW-1:0] MarkZero    = 16'd0;
	localparam logic [LevelW-1:0] MarkOne     = 16'd1;
	localparam logic [LevelW-1:0] MarkTop     = 16'd65535;
	localparam logic [LevelW-1:0] MarkTopLess = 16'd65534;

	localparam logic [CfgIndexW-1:0] RegPhaseOffset   = 3'd0;
	localparam logic [CfgIndexW-1:0] RegPhaseIir      = 3'd1;
	localparam logic [CfgIndexW-1:0] RegBatteryOffset = 3'd2;
	localparam logic [CfgIndexW-1:0] RegCurrentOffset = 3'd3;
	localparam logic [CfgIndexW-1:0] RegCurrentIir    = 3'd4;

	localparam logic [OffsetW-1:0] CurrentOffsetReset = 16'd2045;
	localparam logic [WeightW-1:0] CurrentIirReset    = 8'd20;

	typedef struct packed {
		logic [OffsetW-1:0] phase_offset;
		logic [WeightW-1:0] phase_iir;
		logic [OffsetW-1:0] battery_offset;
		logic [OffsetW-1:0] current_offset;
		logic [WeightW-1:0] current_iir;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [LevelW-1:0]  level;
		logic [SampleW-1:0] sample;
		logic [OffsetW-1:0] offset;
		logic [WeightW-1:0] weight;
	} iir_req_t;

	typedef enum logic [2:0] {
		IIR_IDLE = 3'b001,
		IIR_MUL  = 3'b010,
		IIR_DIV  = 3'b100
	} iir_state_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_HOLD = 3'b100
	} ctl_state_t;

endpackage

>>> hw/rtl/motor_sensor_filter_core.sv
// Channel | Direction | Signals                          | Payload
// s       | in        | s_tvalid s_tready s_tdata        | three 12-bit samples
// m       | out       | m_tvalid m_tready m_tdata m_tuser | three 16-bit levels, slow flag
// cfg     | in        | cfg_valid cfg_ready              | cfg_index, cfg_data
//
// A word is taken only once the last one is in the output register. The work on
// it is the load, 8 multiply steps and 32 division steps in the two serial filter
// units, which run side by side, then taking the results and filling the output register.
// The output register holds a finished word while the next one is computed.
// arst_n clears the control state, levels, slow counter and output valid flag.
// While the output word stalls, one more word is taken and waits once computed;
// no further word is taken until the stalled word is out.
module motor_sensor_filter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// phase_sample, battery_sample, current_sample, zero fill
	input  logic [39:0]                          s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// phase_level, half_rail_level, current_level
	output logic [47:0]                          m_tdata,
	// slow_updated
	output logic [0:0]                           m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [msf_pkg::CfgIndexW-1:0]        cfg_index,
	input  logic [msf_pkg::CfgDataW-1:0]         cfg_data
);
	import msf_pkg::*;

	cfg_t               cfg;
	ctl_state_t         state_q;
	logic [LevelW-1:0]  phase_q;
	logic [LevelW-1:0]  half_rail_q;
	logic [LevelW-1:0]  current_q;
	logic [CountW-1:0]  slow_count_q;
	logic               slow_q;
	logic               phase_filt_q;
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;
	logic               m_tuser_q;

	logic [SampleW-1:0] ph_sample;
	logic [SampleW-1:0] bat_sample;
	logic [SampleW-1:0] cur_sample;
	logic               accept;
	logic               load_out;
	logic               slow_now;
	logic [LevelW-1:0]  hr_base;
	logic [LevelW-1:0]  hr_target;
	logic [LevelW-1:0]  hr_next;
	iir_req_t           ph_req;
	iir_req_t           cu_req;
	logic               ph_done;
	logic               cu_done;
	logic [LevelW-1:0]  ph_result;
	logic [LevelW-1:0]  cu_result;

	assign ph_sample  = s_tdata[11:0];
	assign bat_sample = s_tdata[23:12];
	assign cur_sample = s_tdata[35:24];

	assign s_tready  = state_q == ST_IDLE;
	assign accept    = s_tvalid && s_tready;
	assign load_out  = state_q == ST_HOLD && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign slow_now  = slow_count_q == SlowLast;

	msf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign ph_req.start  = accept;
	assign ph_req.level  = phase_q;
	assign ph_req.sample = ph_sample;
	assign ph_req.offset = cfg.phase_offset;
	assign ph_req.weight = cfg.phase_iir;

	assign cu_req.start  = accept;
	assign cu_req.level  = current_q;
	assign cu_req.sample = cur_sample;
	assign cu_req.offset = cfg.current_offset;
	assign cu_req.weight = cfg.current_iir;

	msf_iir u_phase_iir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ph_req),
		.done   (ph_done),
		.result (ph_result)
	);

	msf_iir u_current_iir (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cu_req),
		.done   (cu_done),
		.result (cu_result)
	);

	always_comb begin
		hr_base   = (half_rail_q == '0) ? {{(LevelW-SampleW){1'b0}}, bat_sample} : half_rail_q;
		hr_target = {{(LevelW-SampleW){1'b0}}, bat_sample} + cfg.battery_offset;
		priority if (hr_target > hr_base) begin
			hr_next = hr_base + 16'd1;
		end else if (hr_target < hr_base) begin
			hr_next = hr_base - 16'd1;
		end else begin
			hr_next = hr_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= '0;
			half_rail_q  <= '0;
			current_q    <= '0;
			slow_count_q <= '0;
			slow_q       <= 1'b0;
			phase_filt_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_CALC;
						slow_q       <= slow_now;
						priority if (phase_q == MarkZero) begin
							phase_q      <= MarkOne;
							phase_filt_q <= 1'b0;
						end else if (phase_q == MarkOne) begin
							phase_q      <= {{(LevelW-SampleW){1'b0}}, ph_sample};
							phase_filt_q <= 1'b0;
						end else if (phase_q == MarkTop) begin
							phase_q      <= MarkTopLess;
							phase_filt_q <= 1'b0;
						end else if (phase_q == MarkTopLess) begin
							phase_q      <= {{(LevelW-SampleW){1'b0}}, ph_sample};
							phase_filt_q <= 1'b0;
						end else begin
							phase_filt_q <= 1'b1;
						end
						if (slow_now) begin
							slow_count_q <= '0;
							half_rail_q  <= hr_next;
						end else begin
							slow_count_q <= slow_count_q + 8'd1;
						end
					end
				end
				ST_CALC: begin
					if (ph_done) begin
						state_q <= ST_HOLD;
						if (phase_filt_q) begin
							phase_q <= ph_result;
						end
						if (slow_q) begin
							current_q <= cu_result;
						end
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {current_q, half_rail_q, phase_q};
			m_tuser_q <= slow_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CALC)
		else $error("accepted word did not start the filter units");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		ph_done |-> state_q == ST_CALC)
		else $error("filter result arrived outside the compute phase");

	a_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ph_done == cu_done)
		else $error("phase and current units finished apart");

	a_slow_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && slow_q) |-> slow_count_q == '0)
		else $error("slow update without the counter restarting");

endmodule

>>> hw/rtl/msf_cfg.sv
module msf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [msf_pkg::CfgIndexW-1:0]   wr_index,
	input  logic [msf_pkg::CfgDataW-1:0]    wr_data,
	output msf_pkg::cfg_t                   cfg
);
	import msf_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_offset   <= '0;
			cfg_q.phase_iir      <= '0;
			cfg_q.battery_offset <= '0;
			cfg_q.current_offset <= CurrentOffsetReset;
			cfg_q.current_iir    <= CurrentIirReset;
		end else if (wr_en) begin
			unique case (wr_index)
				RegPhaseOffset:   cfg_q.phase_offset   <= wr_data;
				RegPhaseIir:      cfg_q.phase_iir      <= wr_data[WeightW-1:0];
				RegBatteryOffset: cfg_q.battery_offset <= wr_data;
				RegCurrentOffset: cfg_q.current_offset <= wr_data;
				RegCurrentIir:    cfg_q.current_iir    <= wr_data[WeightW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/msf_iir.sv
module msf_iir (
	input  logic                          clk,
	input  logic                          arst_n,
	input  msf_pkg::iir_req_t             req,
	output logic                          done,
	output logic [msf_pkg::LevelW-1:0]    result
);
	import msf_pkg::*;

	// The product is built one weight bit per cycle, then the quotient is
	// produced one bit per cycle by restoring division.

	iir_state_t          state_q;
	logic [AccW-1:0]     acc_q;
	logic [AccW-1:0]     mcand_q;
	logic [WeightW-1:0]  weight_q;
	logic [WeightW:0]    divisor_q;
	logic [WeightW:0]    rem_q;
	logic [LevelW-1:0]   quo_q;
	logic [4:0]          cnt_q;
	logic                done_q;

	logic [WeightW+1:0]  trial;
	logic [WeightW+1:0]  diff;
	logic                fits;

	assign trial = {rem_q, acc_q[AccW-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IIR_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == IIR_DIV) && (cnt_q == 5'd31);
			unique case (state_q)
				IIR_IDLE: begin
					if (req.start) begin
						state_q <= IIR_MUL;
						cnt_q   <= '0;
					end
				end
				IIR_MUL: begin
					if (cnt_q[2:0] == 3'd7) begin
						state_q <= IIR_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				IIR_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= IIR_IDLE;
					end
				end
				default: state_q <= IIR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IIR_IDLE: begin
				if (req.start) begin
					acc_q     <= {{(AccW-SampleW){1'b0}}, req.sample}
						+ {{(AccW-OffsetW){req.offset[OffsetW-1]}}, req.offset};
					mcand_q   <= {{(AccW-LevelW){1'b0}}, req.level};
					weight_q  <= req.weight;
					divisor_q <= {1'b0, req.weight} + 9'd1;
				end
			end
			IIR_MUL: begin
				if (weight_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[AccW-2:0], 1'b0};
				weight_q <= {1'b0, weight_q[WeightW-1:1]};
				rem_q    <= '0;
			end
			IIR_DIV: begin
				if (fits) begin
					rem_q <= diff[WeightW:0];
				end else begin
					rem_q <= trial[WeightW:0];
				end
				acc_q <= {acc_q[AccW-2:0], 1'b0};
				quo_q <= {quo_q[LevelW-2:0], fits};
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = quo_q;

endmodule

>>> bench/tb_top.sv
module tb_top;
	import msf_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int RANDOM_ROUNDS = 8;
	localparam int ROUND_WORDS = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 60;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [LevelW-1:0] phase;
		logic [LevelW-1:0] half_rail;
		logic [LevelW-1:0] current;
		logic              slow;
	} levels_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [39:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [47:0]          m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	cfg_t              filter_cfg;
	logic [LevelW-1:0] phase_level_q;
	logic [LevelW-1:0] half_rail_q;
	logic [LevelW-1:0] current_q;
	logic [CountW-1:0] slow_count_q;
	levels_t           pending_levels[$];
	int                error_count = 0;
	int                sender_idle_pct = 0;
	int                receiver_stall_pct = 0;
	int                receiver_hold = 0;
	int                quiet_cycles = 0;

	motor_sensor_filter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [LevelW-1:0] iir_average(input logic [LevelW-1:0] level,
			input logic [SampleW-1:0] sample, input logic [OffsetW-1:0] offset,
			input logic [WeightW-1:0] weight);
		logic [AccW-1:0] lv;
		logic [AccW-1:0] wt;
		logic [AccW-1:0] sm;
		logic [AccW-1:0] numerator;
		lv = {16'b0, level};
		wt = {24'b0, weight};
		sm = {20'b0, sample};
		numerator = lv * wt + sm + {{(AccW-OffsetW){offset[OffsetW-1]}}, offset};
		numerator = numerator / (wt + 32'd1);
		return numerator[LevelW-1:0];
	endfunction

	task automatic predict_levels(input logic [SampleW-1:0] ph, bat, cur);
		levels_t           want;
		logic [LevelW-1:0] target;
		want.slow = 1'b0;
		case (phase_level_q)
			MarkZero: phase_level_q = MarkOne;
			MarkOne, MarkTopLess: phase_level_q = {4'b0, ph};
			MarkTop: phase_level_q = MarkTopLess;
			default: phase_level_q = iir_average(phase_level_q, ph, filter_cfg.phase_offset,
				filter_cfg.phase_iir);
		endcase
		if (slow_count_q == SlowLast) begin
			want.slow = 1'b1;
			slow_count_q = '0;
			if (half_rail_q == '0)
				half_rail_q = {4'b0, bat};
			target = {4'b0, bat} + filter_cfg.battery_offset;
			if (target > half_rail_q)
				half_rail_q = half_rail_q + 16'd1;
			else if (target < half_rail_q)
				half_rail_q = half_rail_q - 16'd1;
			current_q = iir_average(current_q, cur, filter_cfg.current_offset,
				filter_cfg.current_iir);
		end else begin
			slow_count_q = slow_count_q + 8'd1;
		end
		want.phase = phase_level_q;
		want.half_rail = half_rail_q;
		want.current = current_q;
		pending_levels.push_back(want);
	endtask

	function automatic logic [SampleW-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SampleW'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [OffsetW-1:0] pick_offset();
		if ($urandom_range(3) == 0)
			return OffsetW'($urandom);
		return OffsetW'($urandom_range(600)) - 16'd300;
	endfunction

	function automatic logic [WeightW-1:0] pick_weight();
		if ($urandom_range(3) == 0)
			return ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
		return WeightW'($urandom_range(255));
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 53;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 53;
			end
			default: begin
				sender_idle_pct = 24;
				receiver_stall_pct = 24;
			end
		endcase
	endtask

	// A gap, when taken, is long enough to land anywhere in the block's work on a word.
	task automatic send_samples(input logic [SampleW-1:0] ph, bat, cur);
		int gap;
		gap = 0;
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(1, 82);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, cur, bat, ph};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_levels(ph, bat, cur);
	endtask

	task automatic drain_levels();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_levels.size() != 0);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			RegPhaseOffset: filter_cfg.phase_offset = value;
			RegPhaseIir: filter_cfg.phase_iir = value[WeightW-1:0];
			RegBatteryOffset: filter_cfg.battery_offset = value;
			RegCurrentOffset: filter_cfg.current_offset = value;
			RegCurrentIir: filter_cfg.current_iir = value[WeightW-1:0];
			default: ;
		endcase
	endtask

	// The unused upper bits of the data written to the weight registers carry random junk.
	task automatic load_filter_cfg(input cfg_t setting);
		drain_levels();
		write_reg(RegPhaseOffset, setting.phase_offset);
		write_reg(RegPhaseIir, {8'($urandom_range(255)), setting.phase_iir});
		write_reg(RegBatteryOffset, setting.battery_offset);
		write_reg(RegCurrentOffset, setting.current_offset);
		write_reg(RegCurrentIir, {8'($urandom_range(255)), setting.current_iir});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_startup_markers();
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'd4095, 12'd4095, 12'd4095);
		send_samples(12'd2730, 12'd1365, 12'd2730);
	endtask

	task automatic test_phase_markers();
		load_filter_cfg('{16'hFFFF, 8'd0, 16'd0, CurrentOffsetReset, CurrentIirReset});
		send_samples(12'd0, 12'd100, 12'd200);
		send_samples(12'd4095, 12'd100, 12'd200);
		send_samples(12'd4095, 12'd100, 12'd200);
		send_samples(12'd1, 12'd100, 12'd200);
		send_samples(12'd100, 12'd100, 12'd200);
		send_samples(12'd2, 12'd100, 12'd200);
		send_samples(12'd2, 12'd100, 12'd200);
		send_samples(12'd3, 12'd100, 12'd200);
	endtask

	task automatic test_weight_extremes();
		load_filter_cfg('{16'h8000, 8'd255, 16'h7FFF, 16'h8000, 8'd255});
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'd4095, 12'd4095, 12'd4095);
		send_samples(12'd0, 12'd4095, 12'd0);
		load_filter_cfg('{16'h7FFF, 8'd0, 16'h8000, 16'h7FFF, 8'd0});
		send_samples(12'd4095, 12'd0, 12'd4095);
		send_samples(12'd0, 12'd0, 12'd0);
		send_samples(12'd4095, 12'd4095, 12'd4095);
	endtask

	task automatic test_unused_indexes();
		drain_levels();
		for (int i = RegCurrentIir + 1; i < (1 << CfgIndexW); i++) begin
			write_reg(CfgIndexW'(i), CfgDataW'($urandom));
		end
		cfg_valid <= 1'b0;
		send_samples(pick_sample(), pick_sample(), pick_sample());
		send_samples(pick_sample(), pick_sample(), pick_sample());
	endtask

	task automatic test_random_rounds();
		cfg_t setting;
		for (int round = 0; round < RANDOM_ROUNDS; round++) begin
			if (round == 0)
				setting = '{16'h7FFF, 8'd255, 16'h7FFF, 16'h7FFF, 8'd255};
			else if (round == 1)
				setting = '{16'h8000, 8'd0, 16'h8000, 16'h8000, 8'd0};
			else
				setting = '{pick_offset(), pick_weight(), pick_offset(), pick_offset(),
					pick_weight()};
			load_filter_cfg(setting);
			set_idling(idle_mode_t'(round % 4));
			repeat (ROUND_WORDS) send_samples(pick_sample(), pick_sample(), pick_sample());
		end
	endtask

	task automatic test_output_holdoff();
		set_idling(IDLE_NONE);
		receiver_hold = HOLD_CYCLES;
		repeat (30) send_samples(pick_sample(), pick_sample(), pick_sample());
	endtask

	task automatic test_pause_until_drained();
		set_idling(IDLE_BOTH);
		repeat (20) send_samples(pick_sample(), pick_sample(), pick_sample());
		drain_levels();
		repeat (20) send_samples(pick_sample(), pick_sample(), pick_sample());
	endtask

	always @(posedge clk) begin : receiver_pacing
		int stall_burst;
		if (receiver_hold > 0) begin
			receiver_hold = receiver_hold - 1;
			m_tready <= 1'b0;
		end else if (stall_burst > 0) begin
			stall_burst = stall_burst - 1;
			m_tready <= 1'b0;
		end else if (receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct) begin
			m_tready <= 1'b0;
			if ($urandom_range(19) == 0)
				stall_burst = $urandom_range(5, 60);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic compare_field(input string label, input logic [LevelW-1:0] expected,
			input logic [LevelW-1:0] actual);
		if (actual !== expected) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expected, actual);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : level_check
		levels_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_levels.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h %h", $time, m_tdata,
					m_tuser);
				error_count++;
			end else begin
				want = pending_levels.pop_front();
				compare_field("phase_level", want.phase, m_tdata[15:0]);
				compare_field("half_rail_level", want.half_rail, m_tdata[31:16]);
				compare_field("current_level", want.current, m_tdata[47:32]);
				compare_field("slow_updated", {15'b0, want.slow}, {15'b0, m_tuser});
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
			$display("** motor_sensor_filter_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		filter_cfg = '{16'd0, 8'd0, 16'd0, CurrentOffsetReset, CurrentIirReset};
		phase_level_q = MarkZero;
		half_rail_q = '0;
		current_q = '0;
		slow_count_q = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_startup_markers();
		test_phase_markers();
		test_weight_extremes();
		test_unused_indexes();
		test_random_rounds();
		test_output_holdoff();
		test_pause_until_drained();
		drain_levels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** motor_sensor_filter_core: PASSED **");
		end else begin
			$display("** motor_sensor_filter_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/msf_pkg.sv
hw/rtl/msf_cfg.sv
hw/rtl/msf_iir.sv
hw/rtl/motor_sensor_filter_core.sv
bench/tb_top.sv
